@@ design/sta_pkg.sv @@
// Shared constants, codes and types for the sensor time nearest match block.
package sta_pkg;

  localparam int MAX_HITS_DEF = 1024;

  localparam int CMD_W    = 2;
  localparam int CELL_W   = 64;
  localparam int TIME_W   = 32;
  localparam int REF_W    = 32;
  localparam int STATUS_W = 3;
  localparam int MIDX_W   = 10;
  localparam int DELTA_W  = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MATCHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MASK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_WINDOW = 1'd1;

  // One stored reference hit
  typedef struct packed {
    logic [CELL_W-1:0] sensor;
    logic [TIME_W-1:0] hit_time;
  } entry_t;

  // Control handed from the sequencer to the compare unit
  typedef struct packed {
    logic start;
    logic valid;
  } cmp_ctl_t;

endpackage

@@ design/sta_in_if.sv @@
// Request channel carrying command, cell id, time and query reference.
interface sta_in_if;
  logic                          valid;
  logic                          ready;
  logic [sta_pkg::CMD_W-1:0]     cmd;
  logic [sta_pkg::CELL_W-1:0]    cell_id;
  logic signed [sta_pkg::TIME_W-1:0] hit_time;
  logic [sta_pkg::REF_W-1:0]     query_ref;

  modport source (output valid, cmd, cell_id, hit_time, query_ref, input ready);
  modport sink   (input valid, cmd, cell_id, hit_time, query_ref, output ready);
endinterface

@@ design/sta_out_if.sv @@
// Result channel carrying status, match index, delta and echoed reference.
interface sta_out_if;
  logic                            valid;
  logic                            ready;
  logic [sta_pkg::STATUS_W-1:0]    status;
  logic [sta_pkg::MIDX_W-1:0]      match_index;
  logic [sta_pkg::DELTA_W-1:0]     match_delta;
  logic [sta_pkg::REF_W-1:0]       echo_ref;

  modport source (output valid, status, match_index, match_delta, echo_ref, input ready);
  modport sink   (input valid, status, match_index, match_delta, echo_ref, output ready);
endinterface

@@ design/sta_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface sta_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sta_pkg::CFG_IDX_W-1:0]   index;
  logic [sta_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/sta_cell.sv @@
// One storage cell of the hit ring: holds an entry and passes it on when enabled.
module sta_cell (
  input  logic            clk,
  input  logic            en,
  input  sta_pkg::entry_t d,
  output sta_pkg::entry_t q
);

  sta_pkg::entry_t q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

@@ design/sta_cmp.sv @@
// Two-stage compare unit: distance at the ring tail, then best-candidate tracking.
module sta_cmp #(
  parameter int IDX_W = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sta_pkg::cmp_ctl_t             ctl,
  input  logic [IDX_W-1:0]              idx,
  input  sta_pkg::entry_t               tail,
  input  logic [sta_pkg::CELL_W-1:0]    q_sensor,
  input  logic [sta_pkg::TIME_W-1:0]    q_time,
  input  logic [sta_pkg::DELTA_W-1:0]   window,
  output logic                          found,
  output logic [IDX_W-1:0]              best_idx,
  output logic [sta_pkg::DELTA_W-1:0]   best_delta
);

  localparam int TW = sta_pkg::TIME_W;

  logic              hit_a_r;
  logic [TW-1:0]     dist_a_r;
  logic [TW-1:0]     time_a_r;
  logic [IDX_W-1:0]  idx_a_r;

  logic              found_r;
  logic [TW-1:0]     best_dist_r;
  logic [TW-1:0]     best_time_r;
  logic [IDX_W-1:0]  best_idx_r;

  logic signed [TW:0] diff;
  logic [TW:0]        dist_wide;
  logic               in_win;
  logic               better;

  // Stage A: same sensor and absolute time difference
  always_comb begin
    diff      = $signed({tail.hit_time[TW-1], tail.hit_time}) -
                $signed({q_time[TW-1], q_time});
    dist_wide = diff[TW] ? (~diff + 1'b1) : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_a_r <= 1'b0;
    end else begin
      hit_a_r <= ctl.valid && !ctl.start && (tail.sensor == q_sensor);
    end
  end

  always_ff @(posedge clk) begin
    dist_a_r <= dist_wide[TW-1:0];
    time_a_r <= tail.hit_time;
    idx_a_r  <= idx;
  end

  // Stage B: keep the closest candidate; ties go to earlier time, then lower index
  always_comb begin
    in_win = dist_a_r <= {1'b0, window};
    better = !found_r || (dist_a_r < best_dist_r) ||
             ((dist_a_r == best_dist_r) && ($signed(time_a_r) < $signed(best_time_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.start) begin
      found_r <= 1'b0;
    end else if (hit_a_r && in_win) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.start && hit_a_r && in_win && better) begin
      best_dist_r <= dist_a_r;
      best_time_r <= time_a_r;
      best_idx_r  <= idx_a_r;
    end
  end

  assign found      = found_r;
  assign best_idx   = best_idx_r;
  assign best_delta = best_dist_r[sta_pkg::DELTA_W-1:0];

endmodule

@@ design/sensor_time_nearest_match.sv @@
// Top level of the sensor time nearest match block.
// Clear commands and loads of reference hits complete with a registered result, and
// a load past MAX_HITS is dropped with a store full status. Reference hits sit in a
// ring of MAX_HITS cells; a load shifts the ring by one and inserts the new hit. A
// query rotates the whole ring once, one cell per cycle, past a two-stage compare
// unit at the ring tail, whatever the number of stored hits. One item is in work at
// a time. Configuration writes are always ready; register 0 is the sensor mask,
// register 1 the window.
module sensor_time_nearest_match #(
  parameter int MAX_HITS = sta_pkg::MAX_HITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sta_in_if.sink     in_if,
  sta_out_if.source  out_if,
  sta_cfg_if.sink    cfg_if
);

  localparam int IDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int CNT_W = $clog2(MAX_HITS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FLUSH  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                       state_r;
  logic [CNT_W-1:0]                 count_r;
  logic [CNT_W-1:0]                 off_r;
  logic [IDX_W-1:0]                 step_r;
  logic [sta_pkg::CELL_W-1:0]       mask_r;
  logic [sta_pkg::DELTA_W-1:0]      window_r;
  logic [sta_pkg::CELL_W-1:0]       q_sensor_r;
  logic [sta_pkg::TIME_W-1:0]       q_time_r;
  logic [sta_pkg::REF_W-1:0]        q_ref_r;

  logic                             out_valid_r;
  logic [sta_pkg::STATUS_W-1:0]     out_status_r;
  logic [sta_pkg::MIDX_W-1:0]       out_index_r;
  logic [sta_pkg::DELTA_W-1:0]      out_delta_r;
  logic [sta_pkg::REF_W-1:0]        out_ref_r;

  logic             out_free;
  logic             needs_slot;
  logic             in_go;
  logic             full;
  logic             load_shift;
  logic             ring_en;
  logic             finish_go;
  logic             in_range;
  logic [CNT_W-1:0] step_ext;
  logic [IDX_W-1:0] scan_idx;
  logic [31:0]      idx_ext;

  sta_pkg::entry_t   new_entry;
  sta_pkg::entry_t   ring_d [MAX_HITS];
  sta_pkg::entry_t   ring_q [MAX_HITS];
  sta_pkg::cmp_ctl_t cmp_ctl;

  logic                         found;
  logic [IDX_W-1:0]             best_idx;
  logic [sta_pkg::DELTA_W-1:0]  best_delta;

  assign out_free   = !out_valid_r || out_if.ready;
  assign needs_slot = (in_if.cmd == sta_pkg::CMD_CLEAR) || (in_if.cmd == sta_pkg::CMD_LOAD);
  // A query needs the result slot only at its end
  assign in_if.ready = (state_r == S_IDLE) && (out_free || !needs_slot);
  assign in_go       = in_if.valid && in_if.ready;
  assign full        = count_r == CNT_W'(MAX_HITS);
  assign load_shift  = in_go && (in_if.cmd == sta_pkg::CMD_LOAD) && !full;
  assign ring_en     = load_shift || (state_r == S_SCAN);
  assign finish_go   = (state_r == S_FINISH) && out_free;

  assign cfg_if.ready = 1'b1;

  assign new_entry.sensor   = in_if.cell_id & mask_r;
  assign new_entry.hit_time = in_if.hit_time;

  // Ring of cells: cell 0 takes a new hit on load, the tail on rotate
  genvar g;
  generate
    for (g = 0; g < MAX_HITS; g++) begin : g_ring
      if (g == 0) begin : g_head
        assign ring_d[g] = (state_r == S_SCAN) ? ring_q[MAX_HITS-1] : new_entry;
      end else begin : g_body
        assign ring_d[g] = ring_q[g-1];
      end
      sta_cell u_cell (
        .clk (clk),
        .en  (ring_en),
        .d   (ring_d[g]),
        .q   (ring_q[g])
      );
    end
  endgenerate

  // After s rotations the tail holds load index s - (MAX_HITS - count)
  assign step_ext = CNT_W'(step_r);
  assign in_range = step_ext >= off_r;
  assign scan_idx = IDX_W'(step_ext - off_r);

  assign cmp_ctl.start = in_go && (in_if.cmd == sta_pkg::CMD_QUERY);
  assign cmp_ctl.valid = (state_r == S_SCAN) && in_range;

  sta_cmp #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (cmp_ctl),
    .idx        (scan_idx),
    .tail       (ring_q[MAX_HITS-1]),
    .q_sensor   (q_sensor_r),
    .q_time     (q_time_r),
    .window     (window_r),
    .found      (found),
    .best_idx   (best_idx),
    .best_delta (best_delta)
  );

  assign idx_ext = 32'(best_idx);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '1;
      window_r <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        sta_pkg::REG_SENSOR_MASK:  mask_r   <= cfg_if.data;
        sta_pkg::REG_MATCH_WINDOW: window_r <= cfg_if.data[sta_pkg::DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      step_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_go) begin
            case (in_if.cmd)
              sta_pkg::CMD_CLEAR: count_r <= '0;
              sta_pkg::CMD_LOAD: begin
                if (!full) begin
                  count_r <= count_r + 1'b1;
                end
              end
              sta_pkg::CMD_QUERY: begin
                step_r  <= '0;
                state_r <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          step_r <= step_r + 1'b1;
          if (step_r == IDX_W'(MAX_HITS - 1)) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: state_r <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Latch the masked query
  always_ff @(posedge clk) begin
    if (cmp_ctl.start) begin
      q_sensor_r <= new_entry.sensor;
      q_time_r   <= in_if.hit_time;
      q_ref_r    <= in_if.query_ref;
      off_r      <= CNT_W'(MAX_HITS) - count_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_go && needs_slot) || finish_go) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && needs_slot) begin
      if (in_if.cmd == sta_pkg::CMD_CLEAR) begin
        out_status_r <= sta_pkg::ST_CLEARED;
      end else if (full) begin
        out_status_r <= sta_pkg::ST_FULL;
      end else begin
        out_status_r <= sta_pkg::ST_LOADED;
      end
      out_index_r <= '0;
      out_delta_r <= '0;
      out_ref_r   <= '0;
    end else if (finish_go) begin
      out_status_r <= found ? sta_pkg::ST_MATCHED : sta_pkg::ST_NOMATCH;
      out_index_r  <= found ? idx_ext[sta_pkg::MIDX_W-1:0] : '0;
      out_delta_r  <= found ? best_delta : '0;
      out_ref_r    <= q_ref_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.match_index = out_index_r;
  assign out_if.match_delta = out_delta_r;
  assign out_if.echo_ref    = out_ref_r;

endmodule

@@ design/sta_chk.sv @@
// Port-level checker for the sensor time nearest match block, with its bind.
module sta_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [sta_pkg::CMD_W-1:0]       in_cmd,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sta_pkg::STATUS_W-1:0]    out_status,
  input logic [sta_pkg::MIDX_W-1:0]      out_match_index,
  input logic [sta_pkg::DELTA_W-1:0]     out_match_delta
);

  // Hold a pending result until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before being taken");

  // A load request shows its result in the next cycle
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == sta_pkg::CMD_LOAD |=>
      out_valid && (out_status == sta_pkg::ST_LOADED || out_status == sta_pkg::ST_FULL))
    else $error("load result missing or wrong status");

  // A query keeps the block busy while the ring rotates
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == sta_pkg::CMD_QUERY |=> !in_ready)
    else $error("request taken during a query scan");

  // Index and delta are zero unless matched
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sta_pkg::ST_MATCHED |->
      out_match_index == '0 && out_match_delta == '0)
    else $error("index or delta set without a match");

endmodule

bind sensor_time_nearest_match sta_chk u_sta_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_cmd          (in_if.cmd),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_status      (out_if.status),
  .out_match_index (out_if.match_index),
  .out_match_delta (out_if.match_delta)
);
